// ----- hdl/clm_pkg.sv -----
// Package for the cluster map LRU cache: sizes, request/result structs, codes.
// No dependencies.
package clm_pkg;

  localparam int unsigned Entries     = 8;
  localparam int unsigned ClusterBits = 28;
  localparam int unsigned DeviceBits  = 8;
  localparam int unsigned IdxBits     = $clog2(Entries);
  localparam int unsigned QDepth      = 2;

  typedef enum logic [1:0] {
    FUNC_LOOKUP   = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_INV_FILE = 2'd2,
    FUNC_INV_DEV  = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]             func;
    logic [DeviceBits-1:0]  device_id;
    logic [ClusterBits-1:0] first_cluster;
    logic [ClusterBits-1:0] target_cluster;
    logic [ClusterBits-1:0] floor_cluster;
    logic [ClusterBits-1:0] phys_cluster;
  } req_t;

  typedef struct packed {
    logic [ClusterBits-1:0] found_file_cluster;
    logic [ClusterBits-1:0] found_disk_cluster;
    logic                   any_hit;
    logic                   exact_hit;
    logic                   corrupt;
  } res_t;

endpackage

// ----- hdl/clm_front.sv -----
// Front end: accepts requests into a short queue and hands them to the back end.
// Depends on clm_pkg.
module clm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  clm_pkg::req_t req_i,
  output logic          busy_o,
  output logic          q_valid_o,
  output clm_pkg::req_t q_req_o,
  input  logic          q_pop_i
);

  localparam int unsigned PtrBits = $clog2(clm_pkg::QDepth);

  clm_pkg::req_t        mem_q [clm_pkg::QDepth];
  logic [PtrBits-1:0]   wr_q, rd_q;
  logic [PtrBits:0]     cnt_q;
  logic                 push;

  // one request queued at a time: the cache state must settle first
  assign busy_o    = (cnt_q != '0) || q_pop_i;
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_req_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{PtrBits{1'b0}}, push} - {{PtrBits{1'b0}}, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= req_i;
  end

  ap_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= clm_pkg::QDepth) else $error("queue overflow");
  ap_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop of empty queue");
  ap_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !push) else $error("back-to-back push");

endmodule

// ----- hdl/clm_back.sv -----
// Back end: the entry store, recency ranks, compare and update.
// Depends on clm_pkg.
module clm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  clm_pkg::req_t q_req_i,
  output logic          q_pop_o,
  output logic          done_o,
  output clm_pkg::res_t res_o
);

  localparam int unsigned N = clm_pkg::Entries;
  localparam int unsigned IB = clm_pkg::IdxBits;
  localparam int unsigned CB = clm_pkg::ClusterBits;

  logic [N-1:0]                   valid_q;
  logic [clm_pkg::DeviceBits-1:0] dev_q   [N];
  logic [CB-1:0]                  start_q [N];
  logic [CB-1:0]                  idx_q   [N];
  logic [CB-1:0]                  disk_q  [N];
  logic [IB-1:0]                  rank_q  [N];

  // stage 1 registers: per-entry compare results
  logic                 s1_q;
  clm_pkg::req_t        r_q;
  logic [N-1:0]         file_q, dmatch_q, dsame_q, idxeq_q, le_q;

  logic [N-1:0] file_c, dev_c;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      dev_c[i]  = valid_q[i] && (dev_q[i] == q_req_i.device_id);
      file_c[i] = dev_c[i] && (start_q[i] == q_req_i.first_cluster);
    end
  end

  assign q_pop_o = q_valid_i && !s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_q <= 1'b0;
    else         s1_q <= q_pop_o;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      r_q <= q_req_i;
      for (int i = 0; i < N; i++) begin
        file_q[i]   <= file_c[i];
        dmatch_q[i] <= dev_c[i];
        dsame_q[i]  <= (disk_q[i] == q_req_i.phys_cluster);
        idxeq_q[i]  <= (idx_q[i] == q_req_i.floor_cluster);
        le_q[i]     <= (idx_q[i] <= q_req_i.target_cluster);
      end
    end
  end

  // stage 2: selection by rank, then state update
  logic [CB-1:0] best_f, best_d;
  logic          any_c, exact_c, match_c, corrupt_c;
  logic [IB-1:0] sel_c, sel_r, lru_c;
  logic [N-1:0]  qual_c, win_c;
  clm_pkg::res_t res_d;

  // add: most recent key match among ranks below the last
  always_comb begin
    match_c = 1'b0;
    sel_c = '0;
    sel_r = '1;
    lru_c = '0;
    for (int i = 0; i < N; i++) begin
      if (rank_q[i] == IB'(N-1)) lru_c = IB'(i);
      if (file_q[i] && idxeq_q[i] && rank_q[i] != IB'(N-1) &&
          (!match_c || rank_q[i] < sel_r)) begin
        match_c = 1'b1;
        sel_c = IB'(i);
        sel_r = rank_q[i];
      end
    end
    corrupt_c = match_c && !dsame_q[sel_c];
  end

  // lookup: pairwise contest, larger index wins, equal index goes to the lower rank
  always_comb begin
    for (int i = 0; i < N; i++)
      qual_c[i] = file_q[i] && le_q[i] && (idx_q[i] > r_q.floor_cluster) &&
                  (r_q.first_cluster != '0);
    for (int i = 0; i < N; i++) begin
      win_c[i] = qual_c[i];
      for (int j = 0; j < N; j++)
        if (j != i && qual_c[j] && (idx_q[j] > idx_q[i] ||
            (idx_q[j] == idx_q[i] && rank_q[j] < rank_q[i])))
          win_c[i] = 1'b0;
    end
    any_c  = |qual_c;
    best_f = r_q.floor_cluster;
    best_d = r_q.phys_cluster;
    for (int i = 0; i < N; i++)
      if (win_c[i]) begin
        best_f = idx_q[i];
        best_d = disk_q[i];
      end
    exact_c = any_c && (best_f == r_q.target_cluster);
  end

  always_comb begin
    res_d = '0;
    if (r_q.func == clm_pkg::FUNC_LOOKUP) begin
      res_d.found_file_cluster = best_f;
      res_d.found_disk_cluster = best_d;
      res_d.any_hit            = any_c;
      res_d.exact_hit          = exact_c;
    end
    if (r_q.func == clm_pkg::FUNC_ADD) res_d.corrupt = corrupt_c;
  end

  logic [IB-1:0] prom_c;
  logic [IB-1:0] prom_rank;
  assign prom_c    = match_c ? sel_c : lru_c;
  assign prom_rank = rank_q[prom_c];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < N; i++) rank_q[i] <= IB'(i);
    end else if (s1_q) begin
      unique case (clm_pkg::func_e'(r_q.func))
        clm_pkg::FUNC_LOOKUP: ;
        clm_pkg::FUNC_ADD: begin
          if (corrupt_c) valid_q <= valid_q & ~file_q;
          else begin
            if (!match_c) valid_q[prom_c] <= 1'b1;
            for (int i = 0; i < N; i++)
              if (IB'(i) == prom_c) rank_q[i] <= '0;
              else if (rank_q[i] < prom_rank) rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
        clm_pkg::FUNC_INV_FILE: valid_q <= valid_q & ~file_q;
        clm_pkg::FUNC_INV_DEV:  valid_q <= valid_q & ~dmatch_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q && r_q.func == clm_pkg::FUNC_ADD && !match_c) begin
      dev_q[lru_c]   <= r_q.device_id;
      start_q[lru_c] <= r_q.first_cluster;
      idx_q[lru_c]   <= r_q.floor_cluster;
      disk_q[lru_c]  <= r_q.phys_cluster;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= s1_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) res_o <= res_d;
  end

  ap_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |=> done_o) else $error("result missing");
  ap_s1_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |-> !q_pop_o) else $error("overlapping requests");
  ap_corrupt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q && corrupt_c |-> match_c) else $error("corrupt without match");

endmodule

// ----- hdl/cluster_map_lru_cache.sv -----
// Top level of the cluster map LRU cache: front queue plus back-end store.
// Depends on clm_pkg, clm_front, clm_back.
//
// One request at a time through the back end: start is taken when busy is low,
// the request is queued, then popped and compared into the stage 1 registers,
// and the selection and cache update are done from those registers. done_o is
// registered from stage 1 alongside res_o. busy_o is high for one cycle after
// each accepted request; a new request can be taken once the previous one has
// been popped. The receiver cannot stall; done_o is high for exactly one cycle
// per result, and res_o holds each result until the next one.
module cluster_map_lru_cache (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  clm_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output clm_pkg::res_t res_o
);

  logic          q_valid, q_pop;
  clm_pkg::req_t q_req;

  clm_front u_front (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o,
    .q_valid_o(q_valid), .q_req_o(q_req), .q_pop_i(q_pop)
  );

  clm_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_req_i(q_req),
    .q_pop_o(q_pop), .done_o, .res_o
  );

endmodule
